[rtl/core/rnf_pkg.sv]
// ----------------------------------------------------------------------------
// rnf_pkg: shared definitions for the radix number formatter
// Field widths, character codes, sequencer states and the register port type.
// ----------------------------------------------------------------------------
package rnf_pkg;

	localparam int WORD_BITS_DEF = 32;

	localparam int VALUE_W = 32;
	localparam int BASE_W  = 7;
	localparam int RADIX_W = 7;
	localparam int DIGIT_W = 7;
	localparam int CHAR_W  = 8;

	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

	localparam logic [CFG_IDX_W-1:0] REG_CURRENT_RADIX = '0;

	localparam logic [BASE_W-1:0]  BASE_MIN   = 7'd2;
	localparam logic [BASE_W-1:0]  BASE_OCT   = 7'd8;
	localparam logic [BASE_W-1:0]  BASE_HEX   = 7'd16;
	localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 7'd10;
	localparam logic [DIGIT_W-1:0] DIGIT_LIM  = 7'd16;

	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LC_F  = 8'h66;
	localparam logic [CHAR_W-1:0] CH_QMARK = 8'h3F;

	localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
	};

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DIV    = 6'b000010,
		ST_SIGN   = 6'b000100,
		ST_PREFIX = 6'b001000,
		ST_FETCH  = 6'b010000,
		ST_DIGIT  = 6'b100000
	} fmt_state_t;

	typedef struct packed {
		logic                  sel;
		logic                  en;
		logic                  wr;
		logic [CFG_ADDR_W-1:0] addr;
		logic [CFG_DATA_W-1:0] wdata;
	} apb_req_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DIGIT_LIM) begin
			c = DIGIT_CHARS[d[3:0]];
		end else begin
			c = CH_QMARK;
		end
		return c;
	endfunction

endpackage

[rtl/core/rnf_if.sv]
// ----------------------------------------------------------------------------
// rnf_if: item channels of the radix number formatter
// A request channel carrying the word to format and a character channel.
// ----------------------------------------------------------------------------
interface rnf_in_if;
	logic                        valid;
	logic                        ready;
	logic                        cmd;
	logic [rnf_pkg::VALUE_W-1:0] value;
	logic [rnf_pkg::BASE_W-1:0]  base;

	modport source (output valid, output cmd, output value, output base, input ready);
	modport sink   (input valid, input cmd, input value, input base, output ready);
endinterface

interface rnf_out_if;
	logic                       valid;
	logic                       ready;
	logic [rnf_pkg::CHAR_W-1:0] char_out;
	logic                       last;

	modport source (output valid, output char_out, output last, input ready);
	modport sink   (input valid, input char_out, input last, output ready);
endinterface

[rtl/core/rnf_divider.sv]
// ----------------------------------------------------------------------------
// rnf_divider: shared restoring divider
// Divides a word by a 7-bit base, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rnf_divider #(
	parameter int WORD_BITS = rnf_pkg::WORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [WORD_BITS-1:0]         dividend,
	input  logic [rnf_pkg::BASE_W-1:0]   divisor,
	output logic                         done,
	output logic [WORD_BITS-1:0]         quotient,
	output logic [rnf_pkg::DIGIT_W-1:0]  remainder
);

	localparam int CNT_W = $clog2(WORD_BITS);

	logic                         busy_q;
	logic                         done_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [WORD_BITS-1:0]         quot_q;
	logic [rnf_pkg::DIGIT_W-1:0]  rem_q;
	logic [rnf_pkg::BASE_W-1:0]   divisor_q;

	logic [rnf_pkg::DIGIT_W:0]    trial;
	logic [rnf_pkg::DIGIT_W:0]    diff;
	logic                         ge;
	logic                         launch;

	assign launch = start && !busy_q;
	assign trial  = {rem_q, quot_q[WORD_BITS-1]};
	assign ge     = trial >= {1'b0, divisor_q};
	assign diff   = trial - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (launch) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WORD_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (launch) begin
			quot_q    <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[WORD_BITS-2:0], ge};
			rem_q  <= ge ? diff[rnf_pkg::DIGIT_W-1:0] : trial[rnf_pkg::DIGIT_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quot_q;
	assign remainder = rem_q;

endmodule

[rtl/core/rnf_cfg_regs.sv]
// ----------------------------------------------------------------------------
// rnf_cfg_regs: configuration register file
// Holds the user radix behind an APB-style write and read port.
// ----------------------------------------------------------------------------
module rnf_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rnf_pkg::apb_req_t                apb,
	output logic [rnf_pkg::CFG_DATA_W-1:0]   prdata,
	output logic [rnf_pkg::RADIX_W-1:0]      current_radix
);

	logic [rnf_pkg::RADIX_W-1:0]   radix_q;
	logic [rnf_pkg::CFG_IDX_W-1:0] reg_idx;
	logic                          hit;

	assign reg_idx = apb.addr[rnf_pkg::CFG_ADDR_W-1:2];
	assign hit     = reg_idx == rnf_pkg::REG_CURRENT_RADIX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= '0;
		end else if (apb.sel && apb.en && apb.wr && hit) begin
			radix_q <= apb.wdata[rnf_pkg::RADIX_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = {{(rnf_pkg::CFG_DATA_W - rnf_pkg::RADIX_W){1'b0}}, radix_q};
		end
	end

	assign current_radix = radix_q;

endmodule

[rtl/core/radix_number_formatter.sv]
// ----------------------------------------------------------------------------
// radix_number_formatter: integer to ASCII conversion in a chosen base
// Sequencer, digit store and output register around a shared divider.
// ----------------------------------------------------------------------------
// The request channel (req) takes one item: a command (signed or unsigned),
// a word and a base. The character channel (rsp) returns the item's
// characters one at a time, most significant first: an optional '-', an
// optional prefix and the digits, with last set on the final character.
// The user radix is written and read back through the APB-style port at
// address 0. The user writes it only while the block is idle (not enforced).
//
// Each digit costs one pass through the shared restoring divider, one
// quotient bit per cycle. The digits are stored least significant first
// and read back in reverse through the fetch and digit steps, after the
// sign and prefix steps. req.ready is high only while the sequencer is
// idle, and a new item may be taken while the last character of the
// previous one still waits in the output register.
//
// Reset clears the sequencer, the output register's valid and the radix to
// zero. When the receiver stalls, the current character holds and the
// sequencer waits; nothing is dropped.
// ----------------------------------------------------------------------------
module radix_number_formatter #(
	parameter int WORD_BITS = rnf_pkg::WORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	rnf_in_if.sink                              req,
	rnf_out_if.source                           rsp,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rnf_pkg::CFG_ADDR_W-1:0]      paddr,
	input  logic [rnf_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [rnf_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                pready
);

	localparam int IDX_W = $clog2(WORD_BITS);

	rnf_pkg::fmt_state_t state_q, state_d;

	// Configuration.
	rnf_pkg::apb_req_t               apb;
	logic [rnf_pkg::RADIX_W-1:0]     current_radix;

	assign apb.sel   = psel;
	assign apb.en    = penable;
	assign apb.wr    = pwrite;
	assign apb.addr  = paddr;
	assign apb.wdata = pwdata;
	assign pready    = 1'b1;

	rnf_cfg_regs u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.apb           (apb),
		.prdata        (prdata),
		.current_radix (current_radix)
	);

	// Input decode: low word bits, sign, magnitude and effective base.
	logic                          accept;
	logic [WORD_BITS-1:0]          word_in;
	logic                          neg_in;
	logic [WORD_BITS-1:0]          mag_in;
	logic [rnf_pkg::BASE_W-1:0]    base_in;

	assign req.ready = state_q == rnf_pkg::ST_IDLE;
	assign accept    = req.valid && req.ready;
	assign word_in   = req.value[WORD_BITS-1:0];
	assign neg_in    = !req.cmd && word_in[WORD_BITS-1];
	// The most negative word negates to itself, which is its unsigned magnitude.
	assign mag_in    = neg_in ? (~word_in + 1'b1) : word_in;
	assign base_in   = (req.base < rnf_pkg::BASE_MIN) ? rnf_pkg::BASE_MIN : req.base;

	// Shared divider: started by the accepted item, then again on each
	// nonzero quotient until the word is used up.
	logic                          div_start;
	logic                          div_done;
	logic [WORD_BITS-1:0]          div_quot;
	logic [rnf_pkg::DIGIT_W-1:0]   div_rem;
	logic [WORD_BITS-1:0]          div_dividend;
	logic [rnf_pkg::BASE_W-1:0]    div_divisor;

	logic [rnf_pkg::BASE_W-1:0]    base_q;
	logic                          neg_q;
	logic [rnf_pkg::DIGIT_W-1:0]   lead_q;

	assign div_start    = accept
		|| (state_q == rnf_pkg::ST_DIV && div_done && div_quot != '0);
	assign div_dividend = accept ? mag_in : div_quot;
	assign div_divisor  = accept ? base_in : base_q;

	rnf_divider #(
		.WORD_BITS (WORD_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// Digit store, written least significant first and read back in reverse.
	logic [rnf_pkg::DIGIT_W-1:0]   digit_mem [WORD_BITS];
	logic [rnf_pkg::DIGIT_W-1:0]   rd_data_q;
	logic [IDX_W-1:0]              wr_idx_q;
	logic [IDX_W-1:0]              rd_idx_q;
	logic                          dig_we;

	always_ff @(posedge clk) begin
		if (dig_we) begin
			digit_mem[wr_idx_q] <= div_rem;
		end
		rd_data_q <= digit_mem[rd_idx_q];
	end

	// Prefix selection from the base, the radix and the leading digit.
	logic                          pfx_en;
	logic [rnf_pkg::CHAR_W-1:0]    pfx_char;

	always_comb begin
		pfx_en   = 1'b0;
		pfx_char = rnf_pkg::CH_ZERO;
		if (base_q == current_radix) begin
			pfx_en = lead_q >= rnf_pkg::DIGIT_TEN;
		end else if (current_radix == '0) begin
			if (base_q == rnf_pkg::BASE_HEX) begin
				pfx_en   = 1'b1;
				pfx_char = rnf_pkg::CH_HASH;
			end else if (base_q == rnf_pkg::BASE_OCT && lead_q != '0) begin
				pfx_en = 1'b1;
			end
		end
	end

	// Output register: loads a character only when it is empty or being emptied.
	logic                          out_valid_q;
	logic [rnf_pkg::CHAR_W-1:0]    char_q;
	logic                          last_q;
	logic                          can_load;
	logic                          load_out;
	logic [rnf_pkg::CHAR_W-1:0]    out_char;
	logic                          out_last;

	assign can_load = !out_valid_q || rsp.ready;

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		out_char = rnf_pkg::CH_ZERO;
		out_last = 1'b0;
		dig_we   = 1'b0;
		unique case (state_q)
			rnf_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = rnf_pkg::ST_DIV;
				end
			end
			rnf_pkg::ST_DIV: begin
				if (div_done) begin
					dig_we = 1'b1;
					if (div_quot == '0) begin
						state_d = rnf_pkg::ST_SIGN;
					end
				end
			end
			rnf_pkg::ST_SIGN: begin
				if (!neg_q) begin
					state_d = rnf_pkg::ST_PREFIX;
				end else if (can_load) begin
					load_out = 1'b1;
					out_char = rnf_pkg::CH_MINUS;
					state_d  = rnf_pkg::ST_PREFIX;
				end
			end
			rnf_pkg::ST_PREFIX: begin
				if (!pfx_en) begin
					state_d = rnf_pkg::ST_FETCH;
				end else if (can_load) begin
					load_out = 1'b1;
					out_char = pfx_char;
					state_d  = rnf_pkg::ST_FETCH;
				end
			end
			rnf_pkg::ST_FETCH: begin
				// The stored digit arrives in the read register next cycle.
				state_d = rnf_pkg::ST_DIGIT;
			end
			rnf_pkg::ST_DIGIT: begin
				if (can_load) begin
					load_out = 1'b1;
					out_char = rnf_pkg::digit_char(rd_data_q);
					out_last = rd_idx_q == '0;
					state_d  = (rd_idx_q == '0) ? rnf_pkg::ST_IDLE : rnf_pkg::ST_FETCH;
				end
			end
			default: begin
				state_d = rnf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rnf_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				wr_idx_q <= '0;
			end else if (dig_we) begin
				wr_idx_q <= wr_idx_q + 1'b1;
			end
			if (dig_we) begin
				rd_idx_q <= wr_idx_q;
			end else if (state_q == rnf_pkg::ST_DIGIT && load_out) begin
				rd_idx_q <= rd_idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_q <= base_in;
			neg_q  <= neg_in;
		end
		if (dig_we) begin
			lead_q <= div_rem;
		end
		if (load_out) begin
			char_q <= out_char;
			last_q <= out_last;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.char_out = char_q;
	assign rsp.last     = last_q;

endmodule

[rtl/core/rnf_checker.sv]
// ----------------------------------------------------------------------------
// rnf_checker: port-level assertions for the radix number formatter
// Watches the request and character channels and is bound to the top level.
// ----------------------------------------------------------------------------
module rnf_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [rnf_pkg::CHAR_W-1:0]  out_char,
	input logic                        out_last
);

	logic in_fire;
	logic last_is_digit;

	assign in_fire = in_valid && in_ready;
	assign last_is_digit =
		(out_char >= rnf_pkg::CH_ZERO && out_char <= rnf_pkg::CH_NINE)
		|| (out_char >= rnf_pkg::CH_LC_A && out_char <= rnf_pkg::CH_LC_F)
		|| out_char == rnf_pkg::CH_QMARK;

	// A stalled character holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
		else $error("character changed while stalled");

	// Conversion of an accepted item keeps the request side closed.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("request taken again right after an item");

	a_busy_during_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> ##2 !in_ready)
		else $error("request side open during division");

	// The final character of an item is always a digit or '?'.
	a_last_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |-> last_is_digit)
		else $error("final character is not a digit");

endmodule

bind radix_number_formatter rnf_checker u_rnf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.out_char  (rsp.char_out),
	.out_last  (rsp.last)
);
